/* rtl/core/qavgp_pkg.sv */
`timescale 1ns / 1ps

package qavgp_pkg;

	// plane and kernel limits
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_KERNEL = 16;

	// field and register widths
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int ORG_W      = 7;
	localparam int IMG_W      = 7;
	localparam int KER_W      = 5;
	localparam int ZP_W       = 8;
	localparam int SCALE_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int ADDR_W  = $clog2(MAX_HEIGHT * MAX_WIDTH);
	localparam int CNT_W   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	// signed sum of (pixel - zero point) over a full window
	localparam int SUM_W   = CNT_W + PIX_W + 1;
	localparam int Q_SHIFT = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_HEIGHT,
		REG_IMAGE_WIDTH,
		REG_KERNEL_HEIGHT,
		REG_KERNEL_WIDTH,
		REG_COUNT_INCLUDE_PAD,
		REG_INPUT_ZERO_POINT,
		REG_OUTPUT_ZERO_POINT,
		REG_SCALE_RATIO
	} cfg_reg_t;

	// configuration with dimensions already saturated to their legal range
	typedef struct packed {
		logic [IMG_W-1:0]   height;
		logic [IMG_W-1:0]   width;
		logic [KER_W-1:0]   kernel_h;
		logic [KER_W-1:0]   kernel_w;
		logic               include_pad;
		logic [ZP_W-1:0]    in_zp;
		logic [ZP_W-1:0]    out_zp;
		logic [SCALE_W-1:0] scale;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic signed [ORG_W-1:0] top;
		logic signed [ORG_W-1:0] left;
	} scan_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        count;
	} scan_rsp_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] pooled;
		logic             empty;
	} quant_rsp_t;

	function automatic logic [IMG_W-1:0] sat_img(logic [IMG_W-1:0] v, logic [IMG_W-1:0] hi);
		logic [IMG_W-1:0] r;
		r = v;
		if (v == '0) r = IMG_W'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

	function automatic logic [KER_W-1:0] sat_ker(logic [KER_W-1:0] v, logic [KER_W-1:0] hi);
		logic [KER_W-1:0] r;
		r = v;
		if (v == '0) r = KER_W'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

/* rtl/core/qavgp_if.sv */
`timescale 1ns / 1ps

interface qavgp_item_if import qavgp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic [ROW_W-1:0]        pixel_row;
	logic [COL_W-1:0]        pixel_col;
	logic [PIX_W-1:0]        pixel_value;
	logic signed [ORG_W-1:0] window_top;
	logic signed [ORG_W-1:0] window_left;

	modport source(output valid, operation, pixel_row, pixel_col, pixel_value,
		window_top, window_left, input ready);
	modport sink(input valid, operation, pixel_row, pixel_col, pixel_value,
		window_top, window_left, output ready);
endinterface

interface qavgp_result_if import qavgp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pooled_value;
	logic             empty_window;

	modport source(output valid, pooled_value, empty_window, input ready);
	modport sink(input valid, pooled_value, empty_window, output ready);
endinterface

/* rtl/core/qavgp_plane.sv */
`timescale 1ns / 1ps

module qavgp_plane import qavgp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             wr_en,
	input  logic [ROW_W-1:0] wr_row,
	input  logic [COL_W-1:0] wr_col,
	input  logic [PIX_W-1:0] wr_value,
	input  scan_req_t        req,
	output scan_rsp_t        rsp
);

	logic [PIX_W-1:0] mem [MAX_HEIGHT * MAX_WIDTH];

	// window bounds, clipped to the image
	logic signed [8:0] top_x, left_x;
	logic signed [8:0] row_lo, row_hi, col_lo, col_hi;
	logic signed [8:0] row_end, col_end;
	logic [KER_W-1:0]  rows, cols;
	logic              no_pixels;

	always_comb begin
		top_x   = {{2{req.top[ORG_W-1]}}, req.top};
		left_x  = {{2{req.left[ORG_W-1]}}, req.left};
		row_lo  = (top_x < 0) ? 9'sd0 : top_x;
		col_lo  = (left_x < 0) ? 9'sd0 : left_x;
		row_end = top_x + $signed({4'b0, cfg.kernel_h});
		col_end = left_x + $signed({4'b0, cfg.kernel_w});
		row_hi  = (row_end < $signed({2'b0, cfg.height})) ? row_end : $signed({2'b0, cfg.height});
		col_hi  = (col_end < $signed({2'b0, cfg.width})) ? col_end : $signed({2'b0, cfg.width});
		if (row_hi < row_lo) row_hi = row_lo;
		if (col_hi < col_lo) col_hi = col_lo;
		rows      = KER_W'(row_hi - row_lo);
		cols      = KER_W'(col_hi - col_lo);
		no_pixels = (rows == '0) || (cols == '0);
	end

	logic [IMG_W-1:0]  row_q, col_q, col_first_q, row_last_q, col_last_q;
	logic              scanning_q;
	logic              rd_valid_s1, rd_last_s1;
	logic [PIX_W-1:0]  rd_data_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic              last_issue;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic signed [PIX_W:0] diff;

	assign last_issue = (row_q == row_last_q) && (col_q == col_last_q);
	assign rd_addr    = ADDR_W'(int'(row_q) * MAX_WIDTH + int'(col_q));
	assign wr_addr    = ADDR_W'(int'(wr_row) * MAX_WIDTH + int'(wr_col));
	assign diff       = $signed({1'b0, rd_data_s1}) - $signed({1'b0, cfg.in_zp});

	// plane store: item writes and window reads never share a cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_value;
		if (scanning_q) rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanning_q  <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			done_q      <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			col_first_q <= '0;
			row_last_q  <= '0;
			col_last_q  <= '0;
			sum_q       <= '0;
			count_q     <= '0;
		end else begin
			done_q      <= 1'b0;
			rd_valid_s1 <= scanning_q;
			rd_last_s1  <= scanning_q && last_issue;
			if (req.start) begin
				sum_q       <= '0;
				count_q     <= CNT_W'(rows * cols);
				row_q       <= IMG_W'(row_lo);
				col_q       <= IMG_W'(col_lo);
				col_first_q <= IMG_W'(col_lo);
				row_last_q  <= IMG_W'(row_hi - 9'sd1);
				col_last_q  <= IMG_W'(col_hi - 9'sd1);
				scanning_q  <= !no_pixels;
				done_q      <= no_pixels;
			end else if (scanning_q) begin
				if (last_issue) begin
					scanning_q <= 1'b0;
				end else if (col_q == col_last_q) begin
					col_q <= col_first_q;
					row_q <= row_q + IMG_W'(1);
				end else begin
					col_q <= col_q + IMG_W'(1);
				end
			end
			if (rd_valid_s1) begin
				sum_q <= sum_q + {{(SUM_W-PIX_W-1){diff[PIX_W]}}, diff};
			end
			if (rd_valid_s1 && rd_last_s1) done_q <= 1'b1;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.sum   = sum_q;
	assign rsp.count = count_q;

endmodule

/* rtl/core/qavgp_requant.sv */
`timescale 1ns / 1ps

module qavgp_requant import qavgp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  scan_rsp_t  scan,
	output quant_rsp_t rsp
);

	localparam int HALF_W = SCALE_W / 2;
	localparam int PROD_W = SUM_W + HALF_W + 1;
	localparam int T_W    = SUM_W + SCALE_W;
	localparam int DEN_W  = CNT_W + Q_SHIFT;
	localparam int REM_W  = DEN_W + PIX_W + 1;
	localparam int STEP_W = $clog2(PIX_W);
	localparam int BIAS_W = ZP_W + CNT_W;

	typedef enum logic [2:0] {
		R_IDLE,
		R_MUL_LO,
		R_MUL_HI,
		R_BIAS,
		R_CHECK,
		R_DIV,
		R_ROUND
	} rstate_t;

	rstate_t                 state_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        div_q;
	logic signed [T_W-1:0]   acc_q;
	logic [REM_W-1:0]        rem_q, dsh_q;
	logic [PIX_W-1:0]        q_q;
	logic [STEP_W-1:0]       step_q;
	logic                    done_q, empty_q;
	logic [PIX_W-1:0]        pooled_q;

	logic [CNT_W-1:0]        area, divisor;
	logic [HALF_W-1:0]       half;
	logic signed [PROD_W-1:0] prod;
	logic [BIAS_W-1:0]       bias;
	logic [DEN_W-1:0]        den;
	logic signed [T_W-1:0]   sat_lim;
	logic [REM_W:0]          twice_rem;
	logic                    round_up;
	logic [PIX_W:0]          q_next;

	assign area    = CNT_W'(cfg.kernel_h * cfg.kernel_w);
	assign divisor = cfg.include_pad ? area : scan.count;
	// one 18x17 multiplier, used for both halves of the scale
	assign half    = (state_q == R_MUL_HI) ? cfg.scale[SCALE_W-1:HALF_W] : cfg.scale[HALF_W-1:0];
	assign prod    = sum_q * $signed({1'b0, half});
	assign bias    = BIAS_W'(cfg.out_zp * div_q);
	assign den     = {div_q, {Q_SHIFT{1'b0}}};
	assign sat_lim = $signed(T_W'({den, {PIX_W{1'b0}}}));
	assign twice_rem = {rem_q, 1'b0};
	assign round_up  = (twice_rem > (REM_W+1)'(den))
		|| ((twice_rem == (REM_W+1)'(den)) && q_q[0]);
	assign q_next    = {1'b0, q_q} + (PIX_W+1)'(round_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= R_IDLE;
			sum_q    <= '0;
			div_q    <= '0;
			acc_q    <= '0;
			rem_q    <= '0;
			dsh_q    <= '0;
			q_q      <= '0;
			step_q   <= '0;
			done_q   <= 1'b0;
			empty_q  <= 1'b0;
			pooled_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (scan.done) begin
						sum_q <= scan.sum;
						div_q <= divisor;
						if (divisor == '0) begin
							pooled_q <= cfg.out_zp;
							empty_q  <= 1'b1;
							done_q   <= 1'b1;
						end else begin
							empty_q <= 1'b0;
							state_q <= R_MUL_LO;
						end
					end
				end
				R_MUL_LO: begin
					acc_q   <= T_W'(prod);
					state_q <= R_MUL_HI;
				end
				R_MUL_HI: begin
					acc_q   <= acc_q + (T_W'(prod) <<< HALF_W);
					state_q <= R_BIAS;
				end
				R_BIAS: begin
					acc_q   <= acc_q + $signed(T_W'({bias, {Q_SHIFT{1'b0}}}));
					state_q <= R_CHECK;
				end
				R_CHECK: begin
					if (acc_q <= 0) begin
						pooled_q <= '0;
						done_q   <= 1'b1;
						state_q  <= R_IDLE;
					end else if (acc_q >= sat_lim) begin
						// quotient at least 256: clamps to full scale
						pooled_q <= '1;
						done_q   <= 1'b1;
						state_q  <= R_IDLE;
					end else begin
						rem_q   <= REM_W'(acc_q);
						dsh_q   <= REM_W'(den) << (PIX_W - 1);
						q_q     <= '0;
						step_q  <= STEP_W'(PIX_W - 1);
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q       <= rem_q - dsh_q;
						q_q[step_q] <= 1'b1;
					end
					dsh_q <= dsh_q >> 1;
					if (step_q == '0) state_q <= R_ROUND;
					else step_q <= step_q - STEP_W'(1);
				end
				R_ROUND: begin
					pooled_q <= q_next[PIX_W] ? '1 : q_next[PIX_W-1:0];
					done_q   <= 1'b1;
					state_q  <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.pooled = pooled_q;
	assign rsp.empty  = empty_q;

endmodule

/* rtl/core/quantized_average_pool_2d.sv */
`timescale 1ns / 1ps
// channel  | dir | beat contents
// ---------+-----+---------------------------------------------------------------
// item     | in  | operation, pixel_row, pixel_col, pixel_value, window_top/left
// result   | out | pooled_value, empty_window (one beat per query, none per write)
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only, no read-back)
//
// a write beat's plane entry is stored at the accepting edge.
// a query reads its n = rows*cols clipped window pixels one a cycle, then requantizes
// the sum; a sum that clamps to zero or full scale skips the divide, and an empty
// window (n is 0, padding not counted) returns the output zero point flagged empty.
// items are taken one at a time; a result stalled by the sink holds the item channel
// until the output register drains. reset clears control state only, no plane clear.

module quantized_average_pool_2d import qavgp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	qavgp_item_if.sink            item,
	qavgp_result_if.source        result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_BUSY,
		T_HOLD
	} tstate_t;

	// raw register values as written
	logic [IMG_W-1:0]   height_q, width_q;
	logic [KER_W-1:0]   kernel_h_q, kernel_w_q;
	logic               include_pad_q;
	logic [ZP_W-1:0]    in_zp_q, out_zp_q;
	logic [SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q      <= IMG_W'(64);
			width_q       <= IMG_W'(64);
			kernel_h_q    <= KER_W'(2);
			kernel_w_q    <= KER_W'(2);
			include_pad_q <= 1'b0;
			in_zp_q       <= '0;
			out_zp_q      <= '0;
			scale_q       <= SCALE_W'(65536);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_HEIGHT:      height_q      <= cfg_data[IMG_W-1:0];
				REG_IMAGE_WIDTH:       width_q       <= cfg_data[IMG_W-1:0];
				REG_KERNEL_HEIGHT:     kernel_h_q    <= cfg_data[KER_W-1:0];
				REG_KERNEL_WIDTH:      kernel_w_q    <= cfg_data[KER_W-1:0];
				REG_COUNT_INCLUDE_PAD: include_pad_q <= cfg_data[0];
				REG_INPUT_ZERO_POINT:  in_zp_q       <= cfg_data[ZP_W-1:0];
				REG_OUTPUT_ZERO_POINT: out_zp_q      <= cfg_data[ZP_W-1:0];
				REG_SCALE_RATIO:       scale_q       <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// dimensions saturate to their legal range before any use
	cfg_t cfg;
	assign cfg.height      = sat_img(height_q, IMG_W'(MAX_HEIGHT));
	assign cfg.width       = sat_img(width_q, IMG_W'(MAX_WIDTH));
	assign cfg.kernel_h    = sat_ker(kernel_h_q, KER_W'(MAX_KERNEL));
	assign cfg.kernel_w    = sat_ker(kernel_w_q, KER_W'(MAX_KERNEL));
	assign cfg.include_pad = include_pad_q;
	assign cfg.in_zp       = in_zp_q;
	assign cfg.out_zp      = out_zp_q;
	assign cfg.scale       = scale_q;

	tstate_t          state_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] pooled_q;
	logic             empty_q;

	logic             accept;
	logic             wr_en;
	logic             out_free;
	scan_req_t        scan_req;
	scan_rsp_t        scan_rsp;
	quant_rsp_t       quant_rsp;

	assign item.ready = (state_q == T_IDLE);
	assign accept     = item.valid && item.ready;
	// a write outside the memory is dropped, one inside it but off the image is kept
	assign wr_en      = accept && (item.operation == OP_WRITE)
		&& (int'(item.pixel_row) < MAX_HEIGHT) && (int'(item.pixel_col) < MAX_WIDTH);

	assign scan_req.start = accept && (item.operation == OP_QUERY);
	assign scan_req.top   = item.window_top;
	assign scan_req.left  = item.window_left;

	// output register can take a new beat when empty or drained this cycle
	assign out_free = !out_valid_q || result.ready;

	qavgp_plane u_plane (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.wr_en    (wr_en),
		.wr_row   (item.pixel_row),
		.wr_col   (item.pixel_col),
		.wr_value (item.pixel_value),
		.req      (scan_req),
		.rsp      (scan_rsp)
	);

	qavgp_requant u_requant (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.scan   (scan_rsp),
		.rsp    (quant_rsp)
	);

	// sequencer and output register; requant result stays put until its next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			pooled_q    <= '0;
			empty_q     <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (scan_req.start) state_q <= T_BUSY;
				end
				T_BUSY: begin
					if (quant_rsp.done) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							pooled_q    <= quant_rsp.pooled;
							empty_q     <= quant_rsp.empty;
							state_q     <= T_IDLE;
						end else begin
							state_q <= T_HOLD;
						end
					end
				end
				T_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						pooled_q    <= quant_rsp.pooled;
						empty_q     <= quant_rsp.empty;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.pooled_value = pooled_q;
	assign result.empty_window = empty_q;

endmodule
